// ----- rtl/interval_booking_no_triple_overlap_unit_assert.svh -----
// Assertion macros used by the interval booking datapath.
// Each use expands to one labeled concurrent assertion clocked by clk, reset by rst.
`ifndef INTERVAL_BOOKING_NO_TRIPLE_OVERLAP_UNIT_ASSERT_SVH
`define INTERVAL_BOOKING_NO_TRIPLE_OVERLAP_UNIT_ASSERT_SVH

// same-cycle implication
`define IBK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IBK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ibk_pkg.sv -----
// Shared types and constants for the interval booking unit.
// No dependencies; used by ibk_ctrl, ibk_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ibk_pkg;

  localparam int MAX_BOOKINGS  = 64;
  localparam int TIME_BITS     = 31;
  localparam int IDX_BITS      = $clog2(MAX_BOOKINGS);
  localparam int CNT_BITS      = $clog2(MAX_BOOKINGS + 1);
  localparam int STATUS_BITS   = 2;
  localparam int IN_DATA_BITS  = ((2 * TIME_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((STATUS_BITS + 7) / 8) * 8;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_TRIPLE   = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] lo;
    logic [TIME_BITS-1:0] hi;
  } span_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic empty_req;
    logic scan_done;
    logic triple;
    logic full;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ibk_datapath.sv -----
// Datapath: booking table memory, two-stage overlap pipeline and overlap registers.
// Depends on ibk_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "interval_booking_no_triple_overlap_unit_assert.svh"

module ibk_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ibk_pkg::TIME_BITS-1:0] start_time,
  input  wire logic [ibk_pkg::TIME_BITS-1:0] end_time,
  input  wire ibk_pkg::dp_cmd_t              cmd,
  output ibk_pkg::dp_stat_t                  stat
);

  ibk_pkg::span_t                    mem [ibk_pkg::MAX_BOOKINGS];
  ibk_pkg::span_t                    rd_data;

  logic [ibk_pkg::TIME_BITS-1:0]     req_start;
  logic [ibk_pkg::TIME_BITS-1:0]     req_end;
  logic                              req_empty;
  logic [ibk_pkg::CNT_BITS-1:0]      count;
  logic [ibk_pkg::CNT_BITS-1:0]      rd_idx;
  logic                              s1_vld;
  logic                              s2_vld;
  logic                              s2_hit;
  ibk_pkg::span_t                    s2_span;
  logic                              triple;
  logic [ibk_pkg::CNT_BITS-1:0]      ocount;
  logic [ibk_pkg::MAX_BOOKINGS-1:0]  ovl_vld;
  ibk_pkg::span_t                    ovl_span [ibk_pkg::MAX_BOOKINGS];

  logic                              rd_en;
  logic [ibk_pkg::TIME_BITS-1:0]     ov_lo;
  logic [ibk_pkg::TIME_BITS-1:0]     ov_hi;
  logic [ibk_pkg::MAX_BOOKINGS-1:0]  ovl_hit;
  logic                              conflict;
  logic                              ovl_we;

  assign rd_en = cmd.scan & ~req_empty & ~triple & (rd_idx != count);

  // overlap of the stored interval with the request
  assign ov_lo = (rd_data.lo > req_start) ? rd_data.lo : req_start;
  assign ov_hi = (rd_data.hi < req_end)   ? rd_data.hi : req_end;

  always_comb begin
    for (int i = 0; i < ibk_pkg::MAX_BOOKINGS; i++) begin
      ovl_hit[i] = ovl_vld[i] & (ovl_span[i].lo < s2_span.hi) & (s2_span.lo < ovl_span[i].hi);
    end
  end

  assign conflict = s2_vld & s2_hit & (|ovl_hit);
  assign ovl_we   = s2_vld & s2_hit & ~conflict & ~triple;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[count[ibk_pkg::IDX_BITS-1:0]] <= '{lo: req_start, hi: req_end};
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[ibk_pkg::IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_start <= start_time;
      req_end   <= end_time;
    end
    if (s1_vld) begin
      s2_hit  <= ov_lo < ov_hi;
      s2_span <= '{lo: ov_lo, hi: ov_hi};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_empty <= 1'b0;
      count     <= '0;
      rd_idx    <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      triple    <= 1'b0;
      ocount    <= '0;
    end else begin
      if (cmd.commit) begin
        count <= count + 1'b1;
      end
      if (cmd.start) begin
        req_empty <= start_time >= end_time;
        rd_idx    <= '0;
        s1_vld    <= 1'b0;
        s2_vld    <= 1'b0;
        triple    <= 1'b0;
        ocount    <= '0;
      end else begin
        if (rd_en) begin
          rd_idx <= rd_idx + 1'b1;
        end
        s1_vld <= rd_en;
        s2_vld <= s1_vld;
        if (conflict) begin
          triple <= 1'b1;
        end
        if (ovl_we) begin
          ocount <= ocount + 1'b1;
        end
      end
    end
  end

  for (genvar g = 0; g < ibk_pkg::MAX_BOOKINGS; g++) begin : g_ovl
    always_ff @(posedge clk) begin
      if (rst) begin
        ovl_vld[g] <= 1'b0;
      end else if (cmd.start) begin
        ovl_vld[g] <= 1'b0;
      end else if (ovl_we && ocount == ibk_pkg::CNT_BITS'(g)) begin
        ovl_vld[g] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (ovl_we && ocount == ibk_pkg::CNT_BITS'(g)) begin
        ovl_span[g] <= s2_span;
      end
    end
  end

  assign stat.empty_req = req_empty;
  assign stat.triple    = triple;
  assign stat.full      = count == ibk_pkg::CNT_BITS'(ibk_pkg::MAX_BOOKINGS);
  assign stat.scan_done = req_empty | triple | ((rd_idx == count) & ~s1_vld & ~s2_vld);

  `IBK_ASSERT_IMPL(a_count_bound, 1'b1, count <= ibk_pkg::CNT_BITS'(ibk_pkg::MAX_BOOKINGS), "booking count overflow")
  `IBK_ASSERT_IMPL(a_ovl_room, ovl_we, ocount < ibk_pkg::CNT_BITS'(ibk_pkg::MAX_BOOKINGS), "overlap store overflow")
  `IBK_ASSERT_IMPL(a_commit_legal, cmd.commit, !req_empty && !triple && !stat.full, "illegal table write")
  `IBK_ASSERT_NEXT(a_start_clears, cmd.start, ocount == '0 && ovl_vld == '0 && !triple, "scan state not cleared")

endmodule

`default_nettype wire

// ----- rtl/ibk_ctrl.sv -----
// Controller: request handshake, scan sequencing and result register.
// Depends on ibk_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ibk_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output ibk_pkg::status_t       status,
  output ibk_pkg::dp_cmd_t       cmd,
  input  wire ibk_pkg::dp_stat_t stat
);

  ibk_pkg::state_t  state;
  ibk_pkg::state_t  state_next;
  ibk_pkg::status_t result;
  logic             out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ibk_pkg::S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= result;
    end
  end

  always_comb begin
    if (stat.empty_req) begin
      result = ibk_pkg::ST_ACCEPTED;
    end else if (stat.triple) begin
      result = ibk_pkg::ST_TRIPLE;
    end else if (stat.full) begin
      result = ibk_pkg::ST_FULL;
    end else begin
      result = ibk_pkg::ST_ACCEPTED;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    cmd           = '0;
    unique case (state)
      ibk_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.start  = 1'b1;
          state_next = ibk_pkg::S_SCAN;
        end
      end
      ibk_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ibk_pkg::S_FINISH;
        end
      end
      ibk_pkg::S_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          cmd.commit = ~stat.empty_req & ~stat.triple & ~stat.full;
          state_next = ibk_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ibk_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/interval_booking_no_triple_overlap_unit.sv -----
// Top level of the interval booking unit: streaming ports, controller, datapath.
// Depends on ibk_pkg, ibk_ctrl and ibk_datapath.
//
// Usage:
//   A request on s_axis carries a half-open interval [start_time, end_time).
//   Each request yields exactly one result on m_axis: status 0 accepted (and
//   stored unless empty), 1 rejected for a triple booking, 2 rejected because
//   the table of MAX_BOOKINGS intervals is full.
//   The table is scanned one stored interval per cycle through a memory read
//   port and a two-stage overlap pipeline; each overlap is checked against all
//   overlaps found so far in parallel. The scan ends early when a triple
//   booking is found, and an empty request skips the scan. The next request
//   is taken in the cycle after the result is loaded; a request is not taken
//   while the previous one is still being scanned.
//   The result sits in an output register; a new request is accepted while it
//   waits. If the receiver stalls, the following result holds in the
//   controller until the register frees, and no further request is taken.
//   Reset (rst, synchronous) empties the table; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module interval_booking_no_triple_overlap_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [30:0] start_time, [61:31] end_time, upper bits zero
  input  wire logic [ibk_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] status, upper bits zero
  output logic [ibk_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata
);

  ibk_pkg::dp_cmd_t  cmd;
  ibk_pkg::dp_stat_t stat;
  ibk_pkg::status_t  status;

  ibk_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status        (status),
    .cmd           (cmd),
    .stat          (stat)
  );

  ibk_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .start_time (s_axis_tdata[ibk_pkg::TIME_BITS-1:0]),
    .end_time   (s_axis_tdata[2*ibk_pkg::TIME_BITS-1:ibk_pkg::TIME_BITS]),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign m_axis_tdata = ibk_pkg::OUT_DATA_BITS'(status);

endmodule

`default_nettype wire

// ----- sim/interval_booking_no_triple_overlap_unit_test.sv -----
// Self-checking testbench for interval_booking_no_triple_overlap_unit.
// Drives interval requests on s_axis and checks each status against a local
// calendar model. Depends only on ibk_pkg and the unit itself.
`timescale 1ns / 1ps

module interval_booking_no_triple_overlap_unit_test;

  localparam int TIME_BITS     = ibk_pkg::TIME_BITS;
  localparam int MAX_BOOKINGS  = ibk_pkg::MAX_BOOKINGS;
  localparam int IN_DATA_BITS  = ibk_pkg::IN_DATA_BITS;
  localparam int OUT_DATA_BITS = ibk_pkg::OUT_DATA_BITS;
  localparam int STATUS_BITS   = ibk_pkg::STATUS_BITS;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_REQS = 730;
  localparam logic [TIME_BITS-1:0] T_MAX = '1;

  typedef struct {
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    bit                   drain_first;
  } booking_req_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // [30:0] start_time, [61:31] end_time, upper bits zero
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // [1:0] status, upper bits zero
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  booking_req_t         pending_reqs[$];
  ibk_pkg::status_t     expected_status[$];
  logic [TIME_BITS-1:0] booked_start[MAX_BOOKINGS];
  logic [TIME_BITS-1:0] booked_end[MAX_BOOKINGS];
  int                   booked_n = 0;
  int                   total_reqs = 1;
  int                   sent_reqs = 0;
  int                   fail_cnt = 0;
  int                   quiet_cycles = 0;

  interval_booking_no_triple_overlap_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [TIME_BITS-1:0] tv(input int unsigned v);
    return TIME_BITS'(v);
  endfunction

  function automatic logic [TIME_BITS-1:0] tmax(input logic [TIME_BITS-1:0] a, b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [TIME_BITS-1:0] tmin(input logic [TIME_BITS-1:0] a, b);
    return (a < b) ? a : b;
  endfunction

  // calendar update for one request; returns the status the unit must give
  function automatic ibk_pkg::status_t book_request(input logic [TIME_BITS-1:0] s, e);
    ibk_pkg::span_t       overlaps[$];
    logic [TIME_BITS-1:0] ov_lo;
    logic [TIME_BITS-1:0] ov_hi;
    if (s >= e) return ibk_pkg::ST_ACCEPTED;
    for (int i = 0; i < booked_n; i++) begin
      ov_lo = tmax(booked_start[i], s);
      ov_hi = tmin(booked_end[i], e);
      if (ov_lo < ov_hi) begin
        foreach (overlaps[j])
          if (tmax(overlaps[j].lo, ov_lo) < tmin(overlaps[j].hi, ov_hi))
            return ibk_pkg::ST_TRIPLE;
        overlaps.insert(overlaps.size(), ibk_pkg::span_t'{lo: ov_lo, hi: ov_hi});
      end
    end
    if (booked_n >= MAX_BOOKINGS) return ibk_pkg::ST_FULL;
    booked_start[booked_n] = s;
    booked_end[booked_n] = e;
    booked_n++;
    return ibk_pkg::ST_ACCEPTED;
  endfunction

  // first third: sender 19 / receiver 57, then swapped, then no idling
  function automatic int idle_pct(input bit rx_side);
    int phase;
    phase = sent_reqs * 3 / total_reqs;
    if (phase >= 2) return 0;
    return (rx_side ^ (phase == 1)) ? 57 : 19;
  endfunction

  task automatic add_req(input logic [TIME_BITS-1:0] s, e, input bit drain = 1'b0);
    booking_req_t r;
    r.start_time = s;
    r.end_time = e;
    r.drain_first = drain;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  always @(posedge clk) begin : drive
    booking_req_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_status.insert(expected_status.size(),
                               book_request(s_axis_tdata[TIME_BITS-1:0],
                                            s_axis_tdata[2*TIME_BITS-1:TIME_BITS]));
        sent_reqs++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain_first && expected_status.size() != 0) &&
            $urandom_range(99) >= idle_pct(1'b0)) begin
          nxt = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {{(IN_DATA_BITS-2*TIME_BITS){1'b0}}, nxt.end_time, nxt.start_time};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : observe
    ibk_pkg::status_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_status.size() == 0) begin
          $error("status: no request outstanding, actual %0d", m_axis_tdata[STATUS_BITS-1:0]);
          fail_cnt++;
        end else begin
          want = expected_status.pop_front();
          if (m_axis_tdata[STATUS_BITS-1:0] !== want) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want, m_axis_tdata[STATUS_BITS-1:0]);
            fail_cnt++;
          end
        end
      end
      m_axis_tready <= $urandom_range(99) >= idle_pct(1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    ibk_pkg::span_t       fresh[$];
    ibk_pkg::span_t       f;
    logic [TIME_BITS-1:0] cursor;
    logic [TIME_BITS-1:0] s;
    logic [TIME_BITS-1:0] e;
    logic [31:0]          r0;
    logic [31:0]          r1;
    int                   pick;

    // empty requests, extremes, touching ends, double and triple bookings
    add_req(tv(0), tv(0));
    add_req(T_MAX, T_MAX);
    add_req(T_MAX, tv(0));
    add_req(tv(10), tv(5));
    add_req(tv(0), tv(1));
    add_req(T_MAX - 1'b1, T_MAX);
    add_req(tv(100), tv(200));
    add_req(tv(150), tv(250));
    add_req(tv(180), tv(190));
    add_req(tv(200), tv(300));
    add_req(tv(200), tv(210));
    add_req(tv(99), tv(100));
    add_req(tv(250), tv(260));
    add_req(tv(260), tv(270));
    add_req(tv(120), tv(130));
    add_req(tv(125), tv(126));
    add_req(tv(90), tv(310));
    add_req(tv(1), tv(99));
    add_req(tv(300), tv(300));

    cursor = tv(1000000);
    for (int k = 0; k < RANDOM_REQS; k++) begin
      pick = $urandom_range(99);
      r0 = $urandom;
      r1 = $urandom;
      if (pick < 8) begin
        s = r0[TIME_BITS-1:0];
        e = $urandom_range(1) ? s : (s >> $urandom_range(1, TIME_BITS - 1));
      end else if (pick < 16) begin
        s = r0[TIME_BITS-1:0];
        e = r1[TIME_BITS-1:0];
      end else if (pick < 40 || fresh.size() == 0) begin
        // new span past every earlier fresh span: fills the table, then hits the full case
        s = TIME_BITS'(cursor + (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 500)));
        e = TIME_BITS'(s + $urandom_range(1, 400));
        cursor = e;
        fresh.insert(fresh.size(), ibk_pkg::span_t'{lo: s, hi: e});
      end else if (pick < 75) begin
        f = fresh[$urandom_range(fresh.size() - 1)];
        case ($urandom_range(3))
          0: begin
            s = f.hi;
            e = TIME_BITS'(s + $urandom_range(1, 50));
          end
          1: begin
            e = f.lo;
            s = TIME_BITS'(e - $urandom_range(1, 50));
          end
          default: begin
            s = TIME_BITS'(f.lo - 1 + $urandom_range(f.hi - f.lo));
            e = TIME_BITS'(s + 1 + $urandom_range(2 * (f.hi - f.lo)));
          end
        endcase
      end else begin
        s = tv($urandom_range(3000));
        e = TIME_BITS'(s + $urandom_range(1, 300));
      end
      add_req(s, e, (k % 150) == 0);
    end
    total_reqs = pending_reqs.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (sent_reqs < total_reqs) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (fail_cnt == 0 && expected_status.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
